// File: sv/bsup_pkg.sv
// shared types and codes of the breaker supervisor
// no dependencies; used by bsup_state and breaker_supervisor_fsm_core
package bsup_pkg;

  // request kinds
  typedef enum logic [2:0] {
    OP_TICK   = 3'd0,
    OP_SHORT  = 3'd1,
    OP_START  = 3'd2,
    OP_RESET  = 3'd3,
    OP_SAFETY = 3'd4
  } op_t;

  // protection verdict carried by a tick
  localparam logic [2:0] V_NONE     = 3'd0;
  localparam logic [2:0] V_WARN     = 3'd1;
  localparam logic [2:0] V_OVERLOAD = 3'd2;
  localparam logic [2:0] V_OVERVOLT = 3'd3;

  // active fault codes
  localparam logic [2:0] F_NONE     = 3'd0;
  localparam logic [2:0] F_OVERLOAD = 3'd1;
  localparam logic [2:0] F_OVERVOLT = 3'd2;
  localparam logic [2:0] F_OTHER    = 3'd3;
  localparam logic [2:0] F_SHORT    = 3'd4;

  // reported mode codes
  localparam logic [2:0] MODE_READY = 3'd0;
  localparam logic [2:0] MODE_RUN   = 3'd1;
  localparam logic [2:0] MODE_WARN  = 3'd2;
  localparam logic [2:0] MODE_FAULT = 3'd3;
  localparam logic [2:0] MODE_RWAIT = 3'd4;
  localparam logic [2:0] MODE_RTRY  = 3'd5;
  localparam logic [2:0] MODE_LOCK  = 3'd6;

  // status flag bit positions
  localparam int SF_NORMAL   = 0;
  localparam int SF_WARN     = 1;
  localparam int SF_OVERLOAD = 2;
  localparam int SF_OVERVOLT = 3;
  localparam int SF_SHORT    = 4;
  localparam int SF_LOCKOUT  = 5;

  localparam logic [5:0] STATUS_RESET = 6'b000001;
  localparam logic [2:0] SAFE_ALL     = 3'b111;
  // ceiling of the recovery wait counter
  localparam logic [15:0] WAIT_COUNT_MAX = 16'hFFFF;

  // configuration register indexes
  localparam logic CFG_TEMP_RETURN   = 1'b0;
  localparam logic CFG_RECOVER_DELAY = 1'b1;

  localparam logic signed [11:0] TEMP_RETURN_RESET = 12'sd800;
  localparam logic [15:0] RECOVER_DELAY_RESET      = 16'd1000;

  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 48;
  localparam int CFG_DATA_W = 16;

  // one request, op in the top bits, rest in s_tdata order
  typedef struct packed {
    op_t                op;
    logic               conditions_ok;
    logic               driver_ok;
    logic               trip_ok;
    logic signed [11:0] temperature;
    logic [2:0]         fault_code;
  } bsup_item_t;

  // one result, laid out as m_tdata from bit 0 up
  typedef struct packed {
    logic [31:0] elapsed_ms;
    logic        log_pulse;
    logic        cmd_result;
    logic [5:0]  flags;
    logic [2:0]  current_fault;
    logic [2:0]  mode;
  } bsup_result_t;

endpackage

// File: sv/bsup_state.sv
// supervisor state registers, config registers and the per-request update
// depends on bsup_pkg
module bsup_state (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          step,
  input  bsup_pkg::bsup_item_t          item,
  input  logic                          cfg_write,
  input  logic                          cfg_index,
  input  logic [bsup_pkg::CFG_DATA_W-1:0] cfg_data,
  output bsup_pkg::bsup_result_t        result
);
  import bsup_pkg::*;

  typedef enum logic [6:0] {
    ST_READY = 7'b0000001,
    ST_RUN   = 7'b0000010,
    ST_WARN  = 7'b0000100,
    ST_FAULT = 7'b0001000,
    ST_RWAIT = 7'b0010000,
    ST_RTRY  = 7'b0100000,
    ST_LOCK  = 7'b1000000
  } state_t;

  state_t             state, state_next;
  logic [2:0]         fault, fault_next;
  logic [5:0]         status, status_next;
  logic [31:0]        ms_count, ms_count_next;
  logic [15:0]        recover_count, recover_count_next;
  logic [2:0]         safety, safety_next;
  logic signed [11:0] temp_return_level;
  logic [15:0]        recover_delay_ms;

  logic [15:0] recover_inc;
  logic        safe_all;
  logic        cmd_result;
  logic        log_pulse;
  logic [2:0]  mode_code;

  always_comb begin
    recover_inc = (recover_count == WAIT_COUNT_MAX) ? recover_count : recover_count + 16'd1;
    safe_all    = (safety == SAFE_ALL);

    state_next         = state;
    fault_next         = fault;
    status_next        = status;
    ms_count_next      = ms_count;
    recover_count_next = recover_count;
    safety_next        = safety;
    cmd_result         = 1'b0;
    log_pulse          = 1'b0;

    case (item.op)
      OP_TICK: begin
        ms_count_next = ms_count + 32'd1;
        unique case (state) inside
          ST_RUN, ST_WARN: begin
            if (item.fault_code == V_WARN) begin
              state_next           = ST_WARN;
              status_next[SF_WARN] = 1'b1;
            end else if (item.fault_code != V_NONE) begin
              status_next[SF_NORMAL] = 1'b0;
              case (item.fault_code)
                V_OVERLOAD: begin
                  fault_next               = F_OVERLOAD;
                  status_next[SF_OVERLOAD] = 1'b1;
                end
                V_OVERVOLT: begin
                  fault_next               = F_OVERVOLT;
                  status_next[SF_OVERVOLT] = 1'b1;
                end
                default: fault_next = F_OTHER;
              endcase
              state_next = ST_FAULT;
              log_pulse  = 1'b1;
            end else if (state == ST_WARN && item.temperature <= temp_return_level) begin
              state_next             = ST_RUN;
              status_next[SF_WARN]   = 1'b0;
              status_next[SF_NORMAL] = 1'b1;
            end
          end
          ST_FAULT: begin
            if (fault == F_OVERLOAD) begin
              state_next         = ST_RWAIT;
              recover_count_next = '0;
            end
          end
          ST_RWAIT: begin
            recover_count_next = recover_inc;
            if (recover_inc >= recover_delay_ms && safe_all) begin
              state_next = ST_RTRY;
            end
          end
          ST_RTRY: begin
            if (safe_all) begin
              fault_next  = F_NONE;
              state_next  = ST_RUN;
              status_next = STATUS_RESET;
            end else begin
              state_next              = ST_LOCK;
              status_next[SF_LOCKOUT] = 1'b1;
            end
          end
          default: ;
        endcase
      end
      OP_SHORT: begin
        fault_next              = F_SHORT;
        state_next              = ST_LOCK;
        status_next[SF_SHORT]   = 1'b1;
        status_next[SF_LOCKOUT] = 1'b1;
        log_pulse               = 1'b1;
      end
      OP_START: begin
        if (state == ST_READY) begin
          state_next  = ST_RUN;
          status_next = STATUS_RESET;
        end else begin
          cmd_result = 1'b1;
        end
      end
      OP_RESET: begin
        if (state == ST_LOCK && safe_all) begin
          fault_next  = F_NONE;
          state_next  = ST_READY;
          status_next = STATUS_RESET;
        end else begin
          cmd_result = 1'b1;
        end
      end
      OP_SAFETY: safety_next = {item.conditions_ok, item.driver_ok, item.trip_ok};
      default: ;
    endcase
  end

  always_comb begin
    unique case (state_next)
      ST_READY: mode_code = MODE_READY;
      ST_RUN:   mode_code = MODE_RUN;
      ST_WARN:  mode_code = MODE_WARN;
      ST_FAULT: mode_code = MODE_FAULT;
      ST_RWAIT: mode_code = MODE_RWAIT;
      ST_RTRY:  mode_code = MODE_RTRY;
      ST_LOCK:  mode_code = MODE_LOCK;
      default:  mode_code = MODE_READY;
    endcase
  end

  assign result = '{elapsed_ms:    ms_count_next,
                    log_pulse:     log_pulse,
                    cmd_result:    cmd_result,
                    flags:         status_next,
                    current_fault: fault_next,
                    mode:          mode_code};

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_READY;
      fault         <= F_NONE;
      status        <= STATUS_RESET;
      ms_count      <= '0;
      recover_count <= '0;
      safety        <= SAFE_ALL;
    end else if (step) begin
      state         <= state_next;
      fault         <= fault_next;
      status        <= status_next;
      ms_count      <= ms_count_next;
      recover_count <= recover_count_next;
      safety        <= safety_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      temp_return_level <= TEMP_RETURN_RESET;
      recover_delay_ms  <= RECOVER_DELAY_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_TEMP_RETURN:   temp_return_level <= cfg_data[11:0];
        CFG_RECOVER_DELAY: recover_delay_ms  <= cfg_data;
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  // lockout is never held without its status bit
  a_lock_flag: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LOCK) |-> status[SF_LOCKOUT])
    else $error("lockout without lockout flag");

  // fault active always names a fault
  a_fault_named: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FAULT) |-> (fault != F_NONE))
    else $error("fault active with no fault");

  // a tick advances the millisecond count by one
  a_tick_count: assert property (@(posedge clk) disable iff (rst)
    (step && item.op == OP_TICK) |=> (ms_count == $past(ms_count) + 32'd1))
    else $error("ms count did not advance on tick");

  // only start and short requests leave ready
  a_ready_exit: assert property (@(posedge clk) disable iff (rst)
    (step && state == ST_READY && item.op != OP_START && item.op != OP_SHORT)
      |=> (state == ST_READY))
    else $error("left ready without start or short");
`endif

endmodule

// File: sv/breaker_supervisor_fsm_core.sv
// top level of the breaker supervisor: request register, state update, result register
// depends on bsup_pkg and bsup_state
//
// Supervisory controller of a solid-state breaker. Each request on the slave
// stream (a 1 ms tick with the protection verdict and temperature, a short
// trip, start, manual reset or safety-flag update) yields exactly one result
// on the master stream with the new mode, active fault, status flags, command
// result, fault-log pulse and millisecond timestamp. Requests pass through an
// input register, the state update is one short combinational step, and the
// result lands in an output register, so one request is taken every cycle
// while the master side takes results; m_tvalid rises when an accepted
// request's result is loaded into the output register. Throughput is otherwise
// bound only by the state update loop; a stalled master side holds the result
// and stops intake once the input register is also full. The two
// configuration registers (temperature return level, recovery delay) are
// written through the cfg port, always ready; write them only while no
// request is in flight, the block itself does not enforce this.
module breaker_supervisor_fsm_core (
  input  logic                            clk,
  input  logic                            rst,
  // request stream
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [bsup_pkg::IN_DATA_W-1:0]  s_tdata,  // fault_code[2:0], temperature[14:3],
                                                    // trip_ok[15], driver_ok[16],
                                                    // conditions_ok[17], zero pad
  input  logic [2:0]                      s_tuser,  // op[2:0]
  // result stream
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [bsup_pkg::OUT_DATA_W-1:0] m_tdata,  // mode[2:0], current_fault[5:3],
                                                    // flag_normal[6], flag_warn[7],
                                                    // flag_overload[8],
                                                    // flag_overvoltage[9], flag_short[10],
                                                    // flag_lockout[11], cmd_result[12],
                                                    // log_pulse[13], elapsed_ms[45:14],
                                                    // zero pad
  // configuration writes
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic                            cfg_index,
  input  logic [bsup_pkg::CFG_DATA_W-1:0] cfg_data
);
  import bsup_pkg::*;

  logic         in_valid;
  bsup_item_t   in_item;
  logic         advance;
  bsup_result_t result;

  // a request moves on when the result register is empty or being drained
  assign advance   = in_valid && (!m_tvalid || m_tready);
  assign s_tready  = !in_valid || advance;
  assign cfg_ready = 1'b1;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item <= bsup_item_t'({s_tuser, s_tdata[17:0]});
    end
  end

  bsup_state u_state (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .item      (in_item),
    .cfg_write (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .result    (result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= {2'b00, result};
    end
  end

endmodule

// File: verif/tb_top.sv
// testbench for breaker_supervisor_fsm_core: directed and random requests checked against
// an in-bench prediction of the supervisor state machine
// depends on bsup_pkg and the breaker_supervisor_fsm_core rtl
`timescale 1ns / 100ps

module tb_top;
  import bsup_pkg::*;

  // request codes that the package leaves unnamed
  localparam logic [2:0] OP_UNUSED_FIRST = 3'd5;
  localparam logic [2:0] OP_UNUSED_LAST  = 3'd7;
  localparam logic [2:0] V_OTHER         = 3'd4;
  localparam logic [2:0] V_ODD_FIRST     = 3'd5;
  localparam logic [2:0] V_ODD_LAST      = 3'd7;

  localparam int CYCLE_LIMIT      = 400000;
  localparam int SETTLE_CYCLES    = 4;   // two-stage pipe plus margin
  localparam int DRAIN_CYCLES     = 8;
  localparam int LONG_HOLD_CYCLES = 64;
  localparam int RESULT_W         = $bits(bsup_result_t);
  localparam logic [15:0] RECOVER_SHORT = 16'd24;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;   // fault_code[2:0], temperature[14:3], trip_ok[15],
                                    // driver_ok[16], conditions_ok[17], zero pad
  logic [2:0]            s_tuser;   // op[2:0]
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;   // mode, current_fault, six flags, cmd_result,
                                    // log_pulse, elapsed_ms[45:14], zero pad
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic                  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // pacing controls shared by the stimulus and the sink
  bit gaps_on   = 1'b1;
  bit long_hold = 1'b0;

  int error_count  = 0;
  int result_count = 0;
  int cycle_count  = 0;

  // predicted supervisor state and configuration
  logic [2:0]         mode_now      = MODE_READY;
  logic [2:0]         fault_now     = F_NONE;
  logic [5:0]         flags_now     = STATUS_RESET;
  logic [31:0]        ms_now        = '0;
  logic [15:0]        recover_now   = '0;
  logic [2:0]         safe_now      = SAFE_ALL;
  logic signed [11:0] temp_return   = TEMP_RETURN_RESET;
  logic [15:0]        recover_delay = RECOVER_DELAY_RESET;

  // results still owed by the block, oldest first
  bsup_result_t breaker_status_q[$];

  string flag_name[6] = '{"flag_normal", "flag_warn", "flag_overload",
                          "flag_overvoltage", "flag_short", "flag_lockout"};

  breaker_supervisor_fsm_core uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // hard stop in case a handshake never completes
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[breaker_supervisor_fsm_core] ERROR");
      $finish;
    end
  end

  // mostly short idle stretches, now and then a long one
  function automatic int pick_gap();
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  // one step of the supervisor: updates the predicted state, returns the result
  function automatic bsup_result_t next_breaker_status(input logic [2:0] op,
                                                       input logic [2:0] code,
                                                       input logic signed [11:0] temp,
                                                       input logic [2:0] safe_in);
    bsup_result_t r;
    logic refused;
    logic log_hit;
    refused = 1'b0;
    log_hit = 1'b0;
    case (op)
      OP_TICK: begin
        ms_now = ms_now + 32'd1;
        if (mode_now == MODE_RUN || mode_now == MODE_WARN) begin
          if (code == V_WARN) begin
            mode_now = MODE_WARN;
            flags_now[SF_WARN] = 1'b1;
          end else if (code != V_NONE) begin
            // any other verdict, odd codes included, is a fault
            flags_now[SF_NORMAL] = 1'b0;
            if (code == V_OVERLOAD) begin
              fault_now = F_OVERLOAD;
              flags_now[SF_OVERLOAD] = 1'b1;
            end else if (code == V_OVERVOLT) begin
              fault_now = F_OVERVOLT;
              flags_now[SF_OVERVOLT] = 1'b1;
            end else begin
              fault_now = F_OTHER;
            end
            mode_now = MODE_FAULT;
            log_hit = 1'b1;
          end else if (mode_now == MODE_WARN && temp <= temp_return) begin
            mode_now = MODE_RUN;
            flags_now[SF_WARN] = 1'b0;
            flags_now[SF_NORMAL] = 1'b1;
          end
        end else if (mode_now == MODE_FAULT && fault_now == F_OVERLOAD) begin
          mode_now = MODE_RWAIT;
          recover_now = '0;
        end else if (mode_now == MODE_RWAIT) begin
          if (recover_now != WAIT_COUNT_MAX) recover_now = recover_now + 16'd1;
          if (recover_now >= recover_delay && safe_now == SAFE_ALL) mode_now = MODE_RTRY;
        end else if (mode_now == MODE_RTRY) begin
          if (safe_now == SAFE_ALL) begin
            fault_now = F_NONE;
            mode_now = MODE_RUN;
            flags_now = STATUS_RESET;
          end else begin
            mode_now = MODE_LOCK;
            flags_now[SF_LOCKOUT] = 1'b1;
          end
        end
      end
      OP_SHORT: begin
        fault_now = F_SHORT;
        mode_now = MODE_LOCK;
        flags_now[SF_SHORT] = 1'b1;
        flags_now[SF_LOCKOUT] = 1'b1;
        log_hit = 1'b1;
      end
      OP_START: begin
        if (mode_now == MODE_READY) begin
          mode_now = MODE_RUN;
          flags_now = STATUS_RESET;
        end else begin
          refused = 1'b1;
        end
      end
      OP_RESET: begin
        if (mode_now == MODE_LOCK && safe_now == SAFE_ALL) begin
          fault_now = F_NONE;
          mode_now = MODE_READY;
          flags_now = STATUS_RESET;
        end else begin
          refused = 1'b1;
        end
      end
      OP_SAFETY: safe_now = safe_in;
      default: ;  // unused op codes only report the state
    endcase
    r.mode          = mode_now;
    r.current_fault = fault_now;
    r.flags         = flags_now;
    r.cmd_result    = refused;
    r.log_pulse     = log_hit;
    r.elapsed_ms    = ms_now;
    return r;
  endfunction

  task automatic report_mismatch(input string field, input longint unsigned got,
                                 input longint unsigned want);
    $display("result %0d: %s is 0x%0h, expected 0x%0h", result_count, field, got, want);
    error_count++;
  endtask

  // offer one request, wait for the handshake, then predict its result
  task automatic send_request(input logic [2:0] op, input logic [2:0] code,
                              input logic [11:0] temp, input logic [2:0] safe);
    int gap;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      gap = pick_gap();
      @(negedge clk);
      s_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {6'b0, safe, temp, code};
    do @(posedge clk); while (!s_tready);
    breaker_status_q.push_back(next_breaker_status(op, code, temp, safe));
  endtask

  // register writes only once the pipe is empty
  task automatic write_register(input logic idx, input logic [15:0] value);
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (breaker_status_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_TEMP_RETURN) temp_return = value[11:0];
    else recover_delay = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // result checker: every accepted result against the oldest prediction
  always @(posedge clk) begin
    bsup_result_t got;
    bsup_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata[RESULT_W-1:0];
      if (breaker_status_q.size() == 0) begin
        report_mismatch("unexpected result", m_tdata, 0);
      end else begin
        want = breaker_status_q.pop_front();
        if (got.mode != want.mode) report_mismatch("mode", got.mode, want.mode);
        if (got.current_fault != want.current_fault)
          report_mismatch("current_fault", got.current_fault, want.current_fault);
        for (int i = 0; i < 6; i++)
          if (got.flags[i] != want.flags[i])
            report_mismatch(flag_name[i], got.flags[i], want.flags[i]);
        if (got.cmd_result != want.cmd_result)
          report_mismatch("cmd_result", got.cmd_result, want.cmd_result);
        if (got.log_pulse != want.log_pulse)
          report_mismatch("log_pulse", got.log_pulse, want.log_pulse);
        if (got.elapsed_ms != want.elapsed_ms)
          report_mismatch("elapsed_ms", got.elapsed_ms, want.elapsed_ms);
        if (m_tdata[OUT_DATA_W-1:RESULT_W] != '0)
          report_mismatch("pad bits", m_tdata[OUT_DATA_W-1:RESULT_W], 0);
      end
      result_count++;
    end
  end

  // result sink: random ready pattern, plus one long hold-off on request
  initial begin : sink_pacing
    int n;
    m_tready = 1'b0;
    @(negedge clk);
    forever begin
      if (long_hold) begin
        // pipe fills up, s_tready must drop while requests keep coming
        m_tready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(negedge clk);
        long_hold = 1'b0;
      end else if (!gaps_on || $urandom_range(0, 3) != 0) begin
        m_tready <= 1'b1;
        n = gaps_on ? $urandom_range(1, 12) : 1;
        repeat (n) @(negedge clk);
      end else begin
        m_tready <= 1'b0;
        repeat (pick_gap()) @(negedge clk);
      end
    end
  end

  // accepted, refused and ignored commands, latched faults, short trip
  task automatic test_commands();
    send_request(OP_TICK, V_OVERLOAD, 12'($urandom), 3'($urandom));  // ignored in ready
    send_request(OP_RESET, 3'($urandom), 12'($urandom), 3'($urandom));  // refused
    send_request(OP_UNUSED_FIRST, 3'($urandom), 12'($urandom), 3'($urandom));
    send_request(OP_START, 3'($urandom), 12'($urandom), 3'($urandom));
    send_request(OP_START, 3'($urandom), 12'($urandom), 3'($urandom));  // already running
    send_request(OP_TICK, V_OVERVOLT, 12'($urandom), 3'($urandom));
    send_request(OP_TICK, V_NONE, 12'($urandom), 3'($urandom));  // overvoltage stays latched
    send_request(OP_RESET, 3'($urandom), 12'($urandom), 3'($urandom));
    send_request(OP_SHORT, 3'($urandom), 12'($urandom), 3'($urandom));
    send_request(OP_SAFETY, 3'($urandom), 12'($urandom), 3'b101);
    send_request(OP_RESET, 3'($urandom), 12'($urandom), 3'($urandom));  // driver flag low
    send_request(OP_SAFETY, 3'($urandom), 12'($urandom), SAFE_ALL);
    send_request(OP_RESET, 3'($urandom), 12'($urandom), 3'($urandom));
    send_request(OP_START, 3'($urandom), 12'($urandom), 3'($urandom));
    send_request(OP_TICK, V_ODD_LAST, 12'($urandom), 3'($urandom));  // odd verdict: other trip
    send_request(OP_SHORT, 3'($urandom), 12'($urandom), 3'($urandom));
    send_request(OP_UNUSED_LAST, 3'($urandom), 12'($urandom), 3'($urandom));
    send_request(OP_RESET, 3'($urandom), 12'($urandom), 3'($urandom));
  endtask

  // warn entry and return around the reset temperature level
  task automatic test_warn_band();
    send_request(OP_START, 3'($urandom), 12'($urandom), 3'($urandom));
    send_request(OP_TICK, V_WARN, 12'sd2047, 3'($urandom));
    send_request(OP_TICK, V_NONE, 12'sd801, 3'($urandom));
    send_request(OP_TICK, V_NONE, 12'sd800, 3'($urandom));
    send_request(OP_TICK, V_WARN, -12'sd2048, 3'($urandom));
    send_request(OP_TICK, V_OTHER, 12'($urandom), 3'($urandom));
    send_request(OP_SHORT, 3'($urandom), 12'($urandom), 3'($urandom));
    send_request(OP_RESET, 3'($urandom), 12'($urandom), 3'($urandom));
  endtask

  // full auto-recovery through a short wait, back-to-back ticks
  task automatic test_recovery_short_delay();
    gaps_on = 1'b0;
    write_register(CFG_RECOVER_DELAY, RECOVER_SHORT);
    send_request(OP_START, 3'($urandom), 12'($urandom), 3'($urandom));
    send_request(OP_TICK, V_OVERLOAD, 12'($urandom), 3'($urandom));
    repeat (RECOVER_SHORT + 3) send_request(OP_TICK, V_NONE, 12'($urandom), 3'($urandom));
    send_request(OP_SHORT, 3'($urandom), 12'($urandom), 3'($urandom));
    send_request(OP_RESET, 3'($urandom), 12'($urandom), 3'($urandom));
    gaps_on = 1'b1;
  endtask

  // register extremes: lowest and highest return level, zero and one ms delay,
  // recovery blocked by safety flags and the try that ends in lockout
  task automatic test_register_extremes();
    write_register(CFG_TEMP_RETURN, {4'($urandom), 12'h800});
    send_request(OP_START, 3'($urandom), 12'($urandom), 3'($urandom));
    send_request(OP_TICK, V_WARN, 12'($urandom), 3'($urandom));
    send_request(OP_TICK, V_NONE, -12'sd2047, 3'($urandom));
    send_request(OP_TICK, V_NONE, -12'sd2048, 3'($urandom));
    write_register(CFG_TEMP_RETURN, {4'($urandom), 12'h7FF});
    send_request(OP_TICK, V_WARN, 12'($urandom), 3'($urandom));
    send_request(OP_TICK, V_NONE, 12'sd2047, 3'($urandom));
    write_register(CFG_RECOVER_DELAY, 16'd0);
    send_request(OP_TICK, V_OVERLOAD, 12'($urandom), 3'($urandom));
    repeat (3) send_request(OP_TICK, V_NONE, 12'($urandom), 3'($urandom));
    send_request(OP_SAFETY, 3'($urandom), 12'($urandom), 3'b110);
    send_request(OP_TICK, V_OVERLOAD, 12'($urandom), 3'($urandom));
    repeat (2) send_request(OP_TICK, V_NONE, 12'($urandom), 3'($urandom));
    send_request(OP_SAFETY, 3'($urandom), 12'($urandom), SAFE_ALL);
    send_request(OP_TICK, V_NONE, 12'($urandom), 3'($urandom));
    send_request(OP_SAFETY, 3'($urandom), 12'($urandom), 3'b011);
    send_request(OP_TICK, V_NONE, 12'($urandom), 3'($urandom));  // try with a flag low: lockout
    send_request(OP_RESET, 3'($urandom), 12'($urandom), 3'($urandom));
    send_request(OP_SAFETY, 3'($urandom), 12'($urandom), SAFE_ALL);
    send_request(OP_RESET, 3'($urandom), 12'($urandom), 3'($urandom));
    write_register(CFG_RECOVER_DELAY, 16'd1);
    send_request(OP_START, 3'($urandom), 12'($urandom), 3'($urandom));
    send_request(OP_TICK, V_OVERLOAD, 12'($urandom), 3'($urandom));
    repeat (4) send_request(OP_TICK, V_NONE, 12'($urandom), 3'($urandom));
    send_request(OP_SHORT, 3'($urandom), 12'($urandom), 3'($urandom));
    send_request(OP_RESET, 3'($urandom), 12'($urandom), 3'($urandom));
  endtask

  // random traffic, weighted toward ticks so recoveries and lockouts recur
  task automatic test_random_traffic(input int items, input bit with_hold);
    int sent;
    int pick;
    logic [2:0] code;
    logic [11:0] temp;
    logic [2:0] safe;
    sent = 0;
    if (with_hold) long_hold = 1'b1;
    while (sent < items) begin
      pick = $urandom_range(0, 99);
      if (pick < 66) begin
        pick = $urandom_range(0, 19);
        if (pick < 10) code = V_NONE;
        else if (pick < 13) code = V_WARN;
        else if (pick < 16) code = V_OVERLOAD;
        else if (pick < 17) code = V_OVERVOLT;
        else if (pick < 18) code = V_OTHER;
        else code = 3'($urandom_range(V_ODD_FIRST, V_ODD_LAST));
        // half near the return level, half anywhere in the field
        if ($urandom_range(0, 1) == 0) temp = temp_return + 12'($urandom_range(0, 16)) - 12'd8;
        else temp = 12'($urandom);
        send_request(OP_TICK, code, temp, 3'($urandom));
        sent++;
      end else if (pick < 74) begin
        send_request(OP_START, 3'($urandom), 12'($urandom), 3'($urandom));
        sent++;
      end else if (pick < 80) begin
        send_request(OP_RESET, 3'($urandom), 12'($urandom), 3'($urandom));
        sent++;
      end else if (pick < 90) begin
        safe = ($urandom_range(0, 2) != 0) ? SAFE_ALL : 3'($urandom);
        send_request(OP_SAFETY, 3'($urandom), 12'($urandom), safe);
        sent++;
      end else if (pick < 94) begin
        send_request(OP_SHORT, 3'($urandom), 12'($urandom), 3'($urandom));
        sent++;
      end else begin
        send_request(3'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST)), 3'($urandom),
                     12'($urandom), 3'($urandom));
      end
    end
  endtask

  initial begin : test_sequence
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = OP_TICK;
    cfg_valid = 1'b0;
    cfg_index = CFG_TEMP_RETURN;
    cfg_data  = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_commands();
    test_warn_band();
    test_recovery_short_delay();
    test_register_extremes();

    // random phases, each with its own register setting
    write_register(CFG_TEMP_RETURN, 16'd0);
    write_register(CFG_RECOVER_DELAY, 16'd2);
    test_random_traffic(100, 1'b0);
    write_register(CFG_TEMP_RETURN, {4'($urandom), 12'($urandom_range(0, 3000) - 1000)});
    write_register(CFG_RECOVER_DELAY, 16'($urandom_range(0, 5)));
    test_random_traffic(100, 1'b1);
    gaps_on = 1'b0;
    write_register(CFG_TEMP_RETURN, 16'hFC18);  // -1000
    write_register(CFG_RECOVER_DELAY, 16'd0);
    test_random_traffic(60, 1'b0);
    gaps_on = 1'b1;
    write_register(CFG_TEMP_RETURN, 16'd2000);
    write_register(CFG_RECOVER_DELAY, 16'($urandom));
    test_random_traffic(60, 1'b0);

    @(negedge clk);
    s_tvalid <= 1'b0;
    while (breaker_status_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) $display("[breaker_supervisor_fsm_core] OK");
    else $display("[breaker_supervisor_fsm_core] ERROR");
    $finish;
  end

endmodule
